// ===== sv/pmct_pkg.sv =====
// Package: shared types and constants for the PS/2 mouse cursor tracker.
`timescale 1ns / 1ps

package pmct_pkg;

    // Field widths
    localparam int COORD_W = 12;
    localparam int PITCH_W = 10;
    localparam int BYTE_W  = 8;
    localparam int BTN_W   = 3;
    localparam int HIT_W   = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Bit positions in the first packet byte
    localparam int SYNC_BIT_IDX   = 3;
    localparam int X_OVF_BIT_IDX  = 6;
    localparam int Y_OVF_BIT_IDX  = 7;
    localparam int CLICK_LEFT_IDX = 0;

    localparam logic [COORD_W-1:0] POS_RESET = 12'd500;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUTTON_LEFT  = 3'd0,
        CFG_BUTTON_PITCH = 3'd1,
        CFG_BUTTON_TOP   = 3'd2,
        CFG_BUTTON_SIZE  = 3'd3,
        CFG_MAX_X        = 3'd4,
        CFG_MAX_Y        = 3'd5
    } t_cfg_idx;

    localparam logic [COORD_W-1:0] BUTTON_LEFT_RST  = 12'd400;
    localparam logic [PITCH_W-1:0] BUTTON_PITCH_RST = 10'd70;
    localparam logic [COORD_W-1:0] BUTTON_TOP_RST   = 12'd400;
    localparam logic [PITCH_W-1:0] BUTTON_SIZE_RST  = 10'd50;
    localparam logic [COORD_W-1:0] MAX_X_RST        = 12'd1023;
    localparam logic [COORD_W-1:0] MAX_Y_RST        = 12'd767;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              from_aux;
    } t_in;

    typedef struct packed {
        logic [COORD_W-1:0] cursor_x;
        logic [COORD_W-1:0] cursor_y;
        logic [BTN_W-1:0]   button_bits;
        logic [HIT_W-1:0]   hit_mask;
    } t_out;

    // Complete, overflow-free packet handed from front to back
    typedef struct packed {
        logic [BTN_W-1:0]  buttons;
        logic [BYTE_W-1:0] dx;
        logic [BYTE_W-1:0] dy;
    } t_pkt;

    // Front -> queue request
    typedef struct packed {
        logic push;
        t_pkt pkt;
    } t_pkt_req;

    // Queue -> back status
    typedef struct packed {
        logic empty;
        t_pkt pkt;
    } t_pkt_head;

    typedef struct packed {
        logic [COORD_W-1:0] button_left;
        logic [PITCH_W-1:0] button_pitch;
        logic [COORD_W-1:0] button_top;
        logic [PITCH_W-1:0] button_size;
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] max_y;
    } t_cfg;

endpackage

// ===== sv/pmct_front.sv =====
// Front end: byte intake, packet framing and overflow filtering.
`timescale 1ns / 1ps

module pmct_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  pmct_pkg::t_in  i_in,
    output pmct_pkg::t_pkt_req o_req
);

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } t_phase;

    t_phase r_phase;
    logic [pmct_pkg::BYTE_W-1:0] r_first;
    logic [pmct_pkg::BYTE_W-1:0] r_second;
    logic take;

    assign take = i_accept && i_in.from_aux;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
        end else if (take) begin
            unique case (r_phase)
                PH_SECOND: begin
                    r_second <= i_in.data_byte;
                    r_phase  <= PH_THIRD;
                end
                PH_THIRD: begin
                    r_phase <= PH_FIRST;
                end
                default: begin
                    // resync: stay here until the sync bit shows up
                    r_first <= i_in.data_byte;
                    r_phase <= i_in.data_byte[pmct_pkg::SYNC_BIT_IDX] ? PH_SECOND : PH_FIRST;
                end
            endcase
        end
    end

    always_comb begin
        o_req.push = take && (r_phase == PH_THIRD)
                     && !r_first[pmct_pkg::X_OVF_BIT_IDX]
                     && !r_first[pmct_pkg::Y_OVF_BIT_IDX];
        o_req.pkt.buttons = r_first[pmct_pkg::BTN_W-1:0];
        o_req.pkt.dx      = r_second;
        o_req.pkt.dy      = i_in.data_byte;
    end

    // an overflowed packet must never reach the queue
    a_no_ovf_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.push |-> (r_first[pmct_pkg::X_OVF_BIT_IDX] == 1'b0)
                    && (r_first[pmct_pkg::Y_OVF_BIT_IDX] == 1'b0))
        else $error("front pushed an overflowed packet");

endmodule

// ===== sv/pmct_fifo.sv =====
// Two-entry packet queue between front and back.
`timescale 1ns / 1ps

module pmct_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pmct_pkg::t_pkt_req   i_req,
    input  logic                 i_pop,
    output logic                 o_full,
    output pmct_pkg::t_pkt_head  o_head
);

    pmct_pkg::t_pkt r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full     = (r_count == 2'd2);
    assign o_head.empty = (r_count == 2'd0);
    assign o_head.pkt   = r_mem[r_rd_ptr];
    assign do_push = i_req.push && !o_full;
    assign do_pop  = i_pop && !o_head.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_req.pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= ~r_wr_ptr;
            if (do_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

    // the front must respect full; a dropped packet would be silent
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.push && o_full))
        else $error("packet pushed into full queue");

endmodule

// ===== sv/pmct_back.sv =====
// Back end: config registers, button hit test, cursor update and result register.
`timescale 1ns / 1ps

module pmct_back #(
    parameter int BUTTON_COUNT = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [pmct_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pmct_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  pmct_pkg::t_pkt_head           i_head,
    output logic                          o_take,
    output logic                          o_valid,
    input  logic                          i_pop,
    output pmct_pkg::t_out                o_out
);

    localparam int HITS = (BUTTON_COUNT < pmct_pkg::HIT_W) ? BUTTON_COUNT : pmct_pkg::HIT_W;
    // left + i*pitch + size, no wrap
    localparam int LO_W = pmct_pkg::COORD_W + 1 + $clog2(BUTTON_COUNT + 1);
    localparam int SUM_W = pmct_pkg::COORD_W + 2;

    pmct_pkg::t_cfg r_cfg;
    logic [pmct_pkg::COORD_W-1:0] r_pos_x;
    logic [pmct_pkg::COORD_W-1:0] r_pos_y;
    logic           r_valid;
    pmct_pkg::t_out r_out;

    logic [SUM_W-1:0] sx;
    logic [SUM_W-1:0] sy;
    logic [pmct_pkg::COORD_W-1:0] nx;
    logic [pmct_pkg::COORD_W-1:0] ny;
    logic [pmct_pkg::HIT_W-1:0]   hits;
    logic                         y_in;
    logic [LO_W-1:0]              lo;
    logic [LO_W-1:0]              xw;

    // config write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.button_left  <= pmct_pkg::BUTTON_LEFT_RST;
            r_cfg.button_pitch <= pmct_pkg::BUTTON_PITCH_RST;
            r_cfg.button_top   <= pmct_pkg::BUTTON_TOP_RST;
            r_cfg.button_size  <= pmct_pkg::BUTTON_SIZE_RST;
            r_cfg.max_x        <= pmct_pkg::MAX_X_RST;
            r_cfg.max_y        <= pmct_pkg::MAX_Y_RST;
        end else if (i_cfg_wr_en) begin
            unique case (pmct_pkg::t_cfg_idx'(i_cfg_idx))
                pmct_pkg::CFG_BUTTON_LEFT:  r_cfg.button_left  <= i_cfg_wdata;
                pmct_pkg::CFG_BUTTON_PITCH:
                    r_cfg.button_pitch <= i_cfg_wdata[pmct_pkg::PITCH_W-1:0];
                pmct_pkg::CFG_BUTTON_TOP:   r_cfg.button_top   <= i_cfg_wdata;
                pmct_pkg::CFG_BUTTON_SIZE:
                    r_cfg.button_size <= i_cfg_wdata[pmct_pkg::PITCH_W-1:0];
                pmct_pkg::CFG_MAX_X:        r_cfg.max_x        <= i_cfg_wdata;
                pmct_pkg::CFG_MAX_Y:        r_cfg.max_y        <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_take  = !i_head.empty && (!r_valid || i_pop);
    assign o_valid = r_valid;
    assign o_out   = r_out;

    // hit test on the old position
    always_comb begin
        y_in = ({1'b0, r_pos_y} >= {1'b0, r_cfg.button_top})
            && ({1'b0, r_pos_y} < ({1'b0, r_cfg.button_top}
                                   + {3'b000, r_cfg.button_size}));
        xw   = LO_W'(r_pos_x);
        hits = '0;
        lo   = '0;
        for (int i = 0; i < HITS; i++) begin
            lo = LO_W'(r_cfg.button_left) + LO_W'(i) * LO_W'(r_cfg.button_pitch);
            hits[i] = y_in && (xw >= lo) && (xw < lo + LO_W'(r_cfg.button_size));
        end
        if (!i_head.pkt.buttons[pmct_pkg::CLICK_LEFT_IDX]) begin
            hits = '0;
        end
    end

    // move and clamp; bit SUM_W-1 set means negative
    always_comb begin
        sx = {2'b00, r_pos_x} + {{(SUM_W-8){i_head.pkt.dx[7]}}, i_head.pkt.dx};
        sy = {2'b00, r_pos_y} - {{(SUM_W-8){i_head.pkt.dy[7]}}, i_head.pkt.dy};
        if (sx[SUM_W-1])
            nx = '0;
        else if (sx[SUM_W-2:0] > {1'b0, r_cfg.max_x})
            nx = r_cfg.max_x;
        else
            nx = sx[pmct_pkg::COORD_W-1:0];
        if (sy[SUM_W-1])
            ny = '0;
        else if (sy[SUM_W-2:0] > {1'b0, r_cfg.max_y})
            ny = r_cfg.max_y;
        else
            ny = sy[pmct_pkg::COORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos_x <= pmct_pkg::POS_RESET;
            r_pos_y <= pmct_pkg::POS_RESET;
        end else begin
            if (o_take) begin
                r_valid <= 1'b1;
                r_pos_x <= nx;
                r_pos_y <= ny;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out.cursor_x    <= nx;
            r_out.cursor_y    <= ny;
            r_out.button_bits <= i_head.pkt.buttons;
            r_out.hit_mask    <= hits;
        end
    end

    a_hit_needs_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_out.hit_mask != '0))
            |-> r_out.button_bits[pmct_pkg::CLICK_LEFT_IDX])
        else $error("hit reported without left button");

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> r_valid && (r_out.cursor_x == r_pos_x) && (r_out.cursor_y == r_pos_y))
        else $error("result register out of step with cursor state");

endmodule

// ===== sv/ps2_mouse_cursor_tracker.sv =====
// Top level: PS/2 mouse packet decoder with cursor tracking and button hit test.
`timescale 1ns / 1ps
// A packet enters the queue with its third byte and is then registered as the result.
// Throughput: one byte request per cycle unless the queue is full; one result per cycle
//   drain rate, as the back end does the hit compares and clamp in parallel.
// Reset (synchronous, active low): phase to first byte, cursor to (500,500),
//   config to defaults, packet queue and result register empty.

module ps2_mouse_cursor_tracker #(
    parameter int BUTTON_COUNT = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // byte intake
    input  logic                            push,
    output logic                            full,
    input  pmct_pkg::t_in                   i_in,
    // results
    output logic                            empty,
    input  logic                            pop,
    output pmct_pkg::t_out                  o_out,
    // config write port
    input  logic                            i_cfg_wr_en,
    input  logic [pmct_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pmct_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    pmct_pkg::t_pkt_req  req;
    pmct_pkg::t_pkt_head head;
    logic                q_full;
    logic                take;
    logic                out_valid;

    // Front only stalls on a full queue; non-aux bytes are still taken and dropped.
    assign full  = q_full;
    assign empty = !out_valid;

    pmct_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (push && !q_full),
        .i_in     (i_in),
        .o_req    (req)
    );

    // Two-entry queue decouples packet framing from the cursor update.
    pmct_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .i_pop   (take),
        .o_full  (q_full),
        .o_head  (head)
    );

    // Back end owns the cursor, the config and the result register.
    pmct_back #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_head      (head),
        .o_take      (take),
        .o_valid     (out_valid),
        .i_pop       (pop),
        .o_out       (o_out)
    );

endmodule

// ===== dv/ps2_mouse_cursor_tracker_tb.sv =====
// Testbench: randomized, self-checking regression for the PS/2 mouse cursor tracker.
`timescale 1ns / 1ps

module ps2_mouse_cursor_tracker_tb;

    localparam int BUTTON_COUNT = 5;

    // Packet assembly phases of the mouse byte stream
    typedef enum logic [1:0] {
        WAIT_HEAD = 2'd0,
        WAIT_DX   = 2'd1,
        WAIT_DY   = 2'd2
    } t_pkt_phase;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            push = 1'b0;
    logic                            full;
    pmct_pkg::t_in                   i_in = '0;
    logic                            empty;
    logic                            pop = 1'b0;
    pmct_pkg::t_out                  o_out;
    logic                            i_cfg_wr_en = 1'b0;
    logic [pmct_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [pmct_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;

    ps2_mouse_cursor_tracker #(.BUTTON_COUNT(BUTTON_COUNT)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Bytes waiting to be offered, and cursor reports the block still owes us
    pmct_pkg::t_in  pending_bytes[$];
    pmct_pkg::t_out cursor_reports[$];

    // Shadow copy of the tracker: register file plus packet and cursor state
    int         btn_left  = int'(pmct_pkg::BUTTON_LEFT_RST);
    int         btn_pitch = int'(pmct_pkg::BUTTON_PITCH_RST);
    int         btn_top   = int'(pmct_pkg::BUTTON_TOP_RST);
    int         btn_size  = int'(pmct_pkg::BUTTON_SIZE_RST);
    int         lim_x     = int'(pmct_pkg::MAX_X_RST);
    int         lim_y     = int'(pmct_pkg::MAX_Y_RST);
    t_pkt_phase pkt_phase = WAIT_HEAD;
    logic [7:0] pkt_head  = '0;
    logic [7:0] pkt_dx    = '0;
    int         cur_x     = int'(pmct_pkg::POS_RESET);
    int         cur_y     = int'(pmct_pkg::POS_RESET);

    int  send_idle_pct = 0;   // chance the sender skips a cycle
    int  stall_pct     = 0;   // chance the receiver skips a cycle
    int  hold_cnt      = 0;   // long receiver hold-off, counted down below
    bit  req_taken     = 1'b0;
    int  errors        = 0;
    int  bytes_taken   = 0;
    int  reports_seen  = 0;
    int  hit_reports   = 0;
    int  drops         = 0;

    // Mask of buttons containing (x, y); compared at full integer width so
    // buttons running past the 12-bit coordinate range never wrap around.
    function automatic logic [pmct_pkg::HIT_W-1:0] buttons_under_cursor(int x, int y);
        logic [pmct_pkg::HIT_W-1:0] mask;
        int lo;
        mask = '0;
        if (y < btn_top || y >= btn_top + btn_size)
            return mask;
        for (int i = 0; i < BUTTON_COUNT && i < pmct_pkg::HIT_W; i++) begin
            lo = btn_left + i * btn_pitch;
            if (x >= lo && x < lo + btn_size)
                mask[i] = 1'b1;
        end
        return mask;
    endfunction

    function automatic int clamp_coord(int v, int hi);
        if (v < 0)
            return 0;
        return (v > hi) ? hi : v;
    endfunction

    // Advance the shadow state by one accepted byte; queue a report when a
    // clean packet completes.
    function automatic void decode_mouse_byte(pmct_pkg::t_in req);
        pmct_pkg::t_out rep;
        logic [pmct_pkg::HIT_W-1:0] hits;
        if (!req.from_aux)
            return;
        case (pkt_phase)
            WAIT_DX: begin
                pkt_dx    = req.data_byte;
                pkt_phase = WAIT_DY;
            end
            WAIT_DY: begin
                pkt_phase = WAIT_HEAD;
                if (pkt_head[pmct_pkg::X_OVF_BIT_IDX] || pkt_head[pmct_pkg::Y_OVF_BIT_IDX]) begin
                    drops++;
                    return;
                end
                // hit test looks at the position before the move
                hits  = pkt_head[pmct_pkg::CLICK_LEFT_IDX] ?
                        buttons_under_cursor(cur_x, cur_y) : '0;
                cur_x = clamp_coord(cur_x + int'($signed(pkt_dx)), lim_x);
                cur_y = clamp_coord(cur_y - int'($signed(req.data_byte)), lim_y);
                rep.cursor_x    = pmct_pkg::COORD_W'(cur_x);
                rep.cursor_y    = pmct_pkg::COORD_W'(cur_y);
                rep.button_bits = pkt_head[pmct_pkg::BTN_W-1:0];
                rep.hit_mask    = hits;
                cursor_reports.push_back(rep);
            end
            default: begin
                // a head byte without the sync bit is thrown away
                pkt_head  = req.data_byte;
                pkt_phase = req.data_byte[pmct_pkg::SYNC_BIT_IDX] ? WAIT_DX : WAIT_HEAD;
            end
        endcase
    endfunction

    function automatic void apply_reg_write(logic [pmct_pkg::CFG_IDX_W-1:0] idx,
                                            logic [pmct_pkg::CFG_DATA_W-1:0] val);
        case (pmct_pkg::t_cfg_idx'(idx))
            pmct_pkg::CFG_BUTTON_LEFT:  btn_left  = int'(val);
            pmct_pkg::CFG_BUTTON_PITCH: btn_pitch = int'(val[pmct_pkg::PITCH_W-1:0]);
            pmct_pkg::CFG_BUTTON_TOP:   btn_top   = int'(val);
            pmct_pkg::CFG_BUTTON_SIZE:  btn_size  = int'(val[pmct_pkg::PITCH_W-1:0]);
            pmct_pkg::CFG_MAX_X:        lim_x     = int'(val);
            pmct_pkg::CFG_MAX_Y:        lim_y     = int'(val);
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, int exp_v, int got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_v, got_v);
            errors++;
        end
    endfunction

    // Sampling side: everything the block accepts is observed at the rising edge.
    always @(posedge i_clk) begin
        pmct_pkg::t_out exp_rep;
        if (i_rst_n) begin
            if (i_cfg_wr_en)
                apply_reg_write(i_cfg_idx, i_cfg_wdata);
            if (push && !full) begin
                decode_mouse_byte(i_in);
                req_taken = 1'b1;
                bytes_taken++;
            end
            if (pop && !empty) begin
                reports_seen++;
                if (o_out.hit_mask != '0)
                    hit_reports++;
                if (cursor_reports.size() == 0) begin
                    $display("%0t: unexpected report, expected none, got %p", $realtime, o_out);
                    errors++;
                end else begin
                    exp_rep = cursor_reports.pop_front();
                    if ($isunknown(o_out)) begin
                        $display("%0t: unknown bits, expected %p, got %p",
                                 $realtime, exp_rep, o_out);
                        errors++;
                    end else begin
                        check_field("cursor_x", int'(exp_rep.cursor_x), int'(o_out.cursor_x));
                        check_field("cursor_y", int'(exp_rep.cursor_y), int'(o_out.cursor_y));
                        check_field("button_bits", int'(exp_rep.button_bits),
                                    int'(o_out.button_bits));
                        check_field("hit_mask", int'(exp_rep.hit_mask), int'(o_out.hit_mask));
                    end
                end
            end
        end
    end

    // Byte driver: holds a request until it is taken, then offers the next
    // one unless the random gap says otherwise.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (push && !req_taken) begin
            push <= 1'b1;
        end else if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            push <= 1'b1;
            i_in <= pending_bytes.pop_front();
        end else begin
            push <= 1'b0;
        end
        req_taken = 1'b0;
    end

    // Report consumer; a pending hold-off keeps pop low regardless of the stall rate
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_cnt != 0)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
    end

    task automatic add_byte(logic [7:0] b, bit aux);
        pmct_pkg::t_in req;
        req.data_byte = b;
        req.from_aux  = aux;
        pending_bytes.push_back(req);
    endtask

    task automatic add_packet(logic [7:0] head, logic [7:0] dx, logic [7:0] dy);
        add_byte(head, 1'b1);
        add_byte(dx, 1'b1);
        add_byte(dy, 1'b1);
    endtask

    function automatic logic [7:0] rand_delta();
        if ($urandom_range(1))
            return 8'($urandom_range(16) - 8);
        return 8'($urandom);
    endfunction

    // Mostly well-formed packets with random content; the rest is keyboard
    // noise, stray mouse bytes that break alignment, and overflow packets.
    task automatic add_random(int n);
        int made;
        int r;
        logic [7:0] head;
        logic [7:0] body[3];
        made = 0;
        while (made < n) begin
            r = $urandom_range(99);
            if (r < 8) begin
                add_byte(8'($urandom), 1'b0);
            end else if (r < 13) begin
                add_byte(8'($urandom), 1'b1);
                made++;
            end else begin
                head = 8'($urandom);
                head[pmct_pkg::SYNC_BIT_IDX] = 1'b1;
                if ($urandom_range(9) != 0) begin
                    head[pmct_pkg::X_OVF_BIT_IDX] = 1'b0;
                    head[pmct_pkg::Y_OVF_BIT_IDX] = 1'b0;
                end
                body[0] = head;
                body[1] = rand_delta();
                body[2] = rand_delta();
                for (int i = 0; i < 3; i++) begin
                    if ($urandom_range(9) == 0)
                        add_byte(8'($urandom), 1'b0);
                    add_byte(body[i], 1'b1);
                end
                made += 3;
            end
        end
    endtask

    task automatic write_reg(pmct_pkg::t_cfg_idx idx, int val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= pmct_pkg::CFG_DATA_W'(val);
    endtask

    // Only called with the block idle; also picks the idling mix for the phase.
    task automatic begin_phase(int left, int pitch, int top, int size, int mx, int my,
                               int send_pct, int stall);
        write_reg(pmct_pkg::CFG_BUTTON_LEFT, left);
        write_reg(pmct_pkg::CFG_BUTTON_PITCH, pitch);
        write_reg(pmct_pkg::CFG_BUTTON_TOP, top);
        write_reg(pmct_pkg::CFG_BUTTON_SIZE, size);
        write_reg(pmct_pkg::CFG_MAX_X, mx);
        write_reg(pmct_pkg::CFG_MAX_Y, my);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        send_idle_pct = send_pct;
        stall_pct     = stall;
    endtask

    // Wait for every byte to be taken and every report to come back, then
    // give the pipeline time to settle any partial packet.
    task automatic drain();
        while (pending_bytes.size() != 0 || push || cursor_reports.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pass on reset defaults: cursor at (500,500), button 0 at
        // x 400..449, y 400..449.
        add_byte(8'hFF, 1'b0);              // keyboard byte, ignored
        add_byte(8'h00, 1'b1);              // head without sync bit, dropped
        add_packet(8'h08, 8'hB0, 8'h50);    // move into button 0 -> (420,420)
        add_packet(8'h09, 8'h00, 8'h00);    // left click on button 0
        add_byte(8'h0F, 1'b1);              // all buttons, keyboard byte mid-packet
        add_byte(8'hAA, 1'b0);
        add_byte(8'h7F, 1'b1);              // largest positive dx
        add_byte(8'h80, 1'b1);              // most negative dy
        add_packet(8'h48, 8'h11, 8'h22);    // x overflow, dropped
        add_packet(8'h88, 8'h33, 8'h44);    // y overflow, dropped
        add_packet(8'hC9, 8'h55, 8'h66);    // both overflow, dropped
        add_packet(8'h0A, 8'h80, 8'h7F);    // right button, full negative x
        drain();

        // Small screen with a dense button row, slow sender
        begin_phase(10, 40, 20, 35, 200, 150, 62, 0);
        add_random(150);
        drain();

        // Everything degenerate: zero limits, all five buttons stacked at the origin
        begin_phase(0, 0, 0, 1, 0, 0, 0, 62);
        add_random(100);
        drain();

        // Top extremes; finish by pushing the cursor into the far corner
        begin_phase(4095, 1023, 4095, 1023, 4095, 4095, 15, 15);
        add_random(100);
        for (int i = 0; i < 34; i++)
            add_packet(8'h08, 8'h7F, 8'h80);
        drain();

        // Limits lowered under the cursor: hit test at the stored corner
        // position, then the move clamps into the new window.
        begin_phase(3000, 200, 3500, 1023, 300, 300, 0, 0);
        add_packet(8'h09, 8'h00, 8'h00);
        add_random(100);
        drain();

        // Zero-size buttons, with a long receiver hold-off so the block backs up
        begin_phase(100, 5, 100, 0, 1023, 767, 0, 0);
        hold_cnt = 400;
        add_random(200);
        drain();

        // Random register values
        begin_phase($urandom_range(4095), $urandom_range(1023), $urandom_range(4095),
                    $urandom_range(1023, 1), $urandom_range(4095), $urandom_range(4095),
                    15, 15);
        add_random(100);
        drain();

        repeat (10) @(posedge i_clk);
        $display("Covered %0d accepted bytes, %0d cursor reports (%0d with button hits),",
                 bytes_taken, reports_seen, hit_reports);
        $display("and %0d overflow packets across seven register setups.", drops);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timed out with %0d reports outstanding", cursor_reports.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
